/* rtl/cst2_pkg.sv */
`timescale 1ns / 1ps

package cst2_pkg;

  localparam int TIME_BITS   = 48;
  localparam int ENERGY_BITS = 16;
  localparam int NUMBER_BITS = 32;
  localparam int WIDTH_BITS  = 32;

  localparam int IN_DATA_BITS  = 64;
  localparam int OUT_DATA_BITS = 40;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(4000);

  localparam logic [1:0] FILL_EMPTY = 2'd0;
  localparam logic [1:0] FILL_ONE   = 2'd1;
  localparam logic [1:0] FILL_PAIR  = 2'd2;

  localparam logic RANK_BEST   = 1'b0;
  localparam logic RANK_SECOND = 1'b1;

  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [ENERGY_BITS-1:0] energy_t;
  typedef logic [NUMBER_BITS-1:0] number_t;
  typedef logic [WIDTH_BITS-1:0]  width_t;

  // coincidence pair handed from the window stage to the output stage
  typedef struct packed {
    number_t best_number;
    number_t second_number;
  } pair_t;

endpackage

/* rtl/coincidence_sorter_top_two.sv */
`timescale 1ns / 1ps

// coincidence sorter keeping the two highest-energy singles of each window
// in_*: one single (or flush) per item; time ordered singles expected
// out_*: a closing window with two or more singles gives two items,
//   the arrival number of the best single (rank 0) then the second (rank 1,
//   tlast high); windows of one single close silently
// cfg_*: window width in ticks, write only while the block is idle
// path: an item is held in the input register, its window decision
//   is made when it leaves it; a resulting pair is on out_* the cycle after
// throughput: one item per cycle, except that an item that closes a full window
//   waits while the single pair buffer in front of out_* still holds the
//   previous pair; it is taken when that pair's second item is accepted
// stalls: a held out_tready stops items only once one that closes a full
//   window is in the input register; until then they flow while the pair waits
// reset: rst_n (synchronous) clears the open window, the arrival counter and
//   both buffers, and sets the window width to 4000 ticks

module coincidence_sorter_top_two (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [47:0] arrival_time, [63:48] energy
  input  logic [cst2_pkg::IN_DATA_BITS-1:0]     in_tdata,
  // [0] flush
  input  logic                                  in_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cst2_pkg::WIDTH_BITS-1:0]       cfg_data,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [31:0] single_number, [32] rank, [39:33] zero
  output logic [cst2_pkg::OUT_DATA_BITS-1:0]    out_tdata,
  output logic                                  out_tlast
);

  logic             pair_vld;
  logic             pair_rdy;
  cst2_pkg::pair_t  pair;

  cst2_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pair_vld  (pair_vld),
    .pair_rdy  (pair_rdy),
    .pair      (pair)
  );

  cst2_pair_out u_pair_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair_vld   (pair_vld),
    .pair_rdy   (pair_rdy),
    .pair       (pair),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/cst2_window.sv */
`timescale 1ns / 1ps

module cst2_window (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [cst2_pkg::IN_DATA_BITS-1:0]     in_tdata,
  input  logic                                  in_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cst2_pkg::WIDTH_BITS-1:0]       cfg_data,
  output logic                                  pair_vld,
  input  logic                                  pair_rdy,
  output cst2_pkg::pair_t                       pair
);

  logic                  width_vld;
  cst2_pkg::width_t      width_r;

  logic                  in_vld_r;
  cst2_pkg::time_t       time_r;
  cst2_pkg::energy_t     energy_r;
  logic                  flush_r;

  logic                  open_r, open_nxt;
  cst2_pkg::time_t       start_r, start_nxt;
  logic [1:0]            fill_r, fill_nxt;
  cst2_pkg::energy_t     best_e_r, best_e_nxt;
  cst2_pkg::number_t     best_n_r, best_n_nxt;
  cst2_pkg::energy_t     second_e_r, second_e_nxt;
  cst2_pkg::number_t     second_n_r, second_n_nxt;
  cst2_pkg::number_t     count_r, count_nxt;

  cst2_pkg::time_t       diff;
  logic                  closes;
  logic                  emits;
  logic                  advance;

  assign cfg_ready = 1'b1;
  assign width_vld = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= cst2_pkg::WIDTH_RESET;
    end else if (width_vld) begin
      width_r <= cfg_data;
    end
  end

  // signed difference from the window start; negative means time went back
  assign diff   = time_r - start_r;
  assign closes = flush_r || !open_r ||
                  (!diff[cst2_pkg::TIME_BITS-1] &&
                   diff >= cst2_pkg::time_t'(width_r));
  assign emits  = closes && open_r && (fill_r == cst2_pkg::FILL_PAIR);

  assign advance   = in_vld_r && (!emits || pair_rdy);
  assign in_tready = !in_vld_r || advance;

  assign pair_vld           = in_vld_r && emits;
  assign pair.best_number   = best_n_r;
  assign pair.second_number = second_n_r;

  always_comb begin
    open_nxt     = open_r;
    start_nxt    = start_r;
    fill_nxt     = fill_r;
    best_e_nxt   = best_e_r;
    best_n_nxt   = best_n_r;
    second_e_nxt = second_e_r;
    second_n_nxt = second_n_r;
    count_nxt    = count_r;
    if (flush_r) begin
      open_nxt = 1'b0;
      fill_nxt = cst2_pkg::FILL_EMPTY;
    end else if (closes) begin
      // new window opens at this single
      count_nxt  = count_r + cst2_pkg::number_t'(1);
      open_nxt   = 1'b1;
      start_nxt  = time_r;
      fill_nxt   = cst2_pkg::FILL_ONE;
      best_e_nxt = energy_r;
      best_n_nxt = count_r;
    end else begin
      count_nxt = count_r + cst2_pkg::number_t'(1);
      if (fill_r == cst2_pkg::FILL_EMPTY) begin
        best_e_nxt = energy_r;
        best_n_nxt = count_r;
        fill_nxt   = cst2_pkg::FILL_ONE;
      end else if (energy_r > best_e_r) begin
        second_e_nxt = best_e_r;
        second_n_nxt = best_n_r;
        best_e_nxt   = energy_r;
        best_n_nxt   = count_r;
        fill_nxt     = cst2_pkg::FILL_PAIR;
      end else if (fill_r == cst2_pkg::FILL_ONE || energy_r > second_e_r) begin
        second_e_nxt = energy_r;
        second_n_nxt = count_r;
        fill_nxt     = cst2_pkg::FILL_PAIR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      open_r     <= 1'b0;
      start_r    <= '0;
      fill_r     <= cst2_pkg::FILL_EMPTY;
      best_e_r   <= '0;
      best_n_r   <= '0;
      second_e_r <= '0;
      second_n_r <= '0;
      count_r    <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        open_r     <= open_nxt;
        start_r    <= start_nxt;
        fill_r     <= fill_nxt;
        best_e_r   <= best_e_nxt;
        best_n_r   <= best_n_nxt;
        second_e_r <= second_e_nxt;
        second_n_r <= second_n_nxt;
        count_r    <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      time_r   <= in_tdata[cst2_pkg::TIME_BITS-1:0];
      energy_r <= in_tdata[cst2_pkg::TIME_BITS +: cst2_pkg::ENERGY_BITS];
      flush_r  <= in_tuser;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("window fill out of range");

  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> fill_r == cst2_pkg::FILL_EMPTY)
    else $error("closed window holds singles");

  a_open_after_single: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !flush_r |=> open_r && fill_r != cst2_pkg::FILL_EMPTY)
    else $error("single did not land in an open window");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && flush_r |=> $stable(count_r))
    else $error("flush consumed an arrival number");

endmodule

/* rtl/cst2_pair_out.sv */
`timescale 1ns / 1ps

module cst2_pair_out (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  pair_vld,
  output logic                                  pair_rdy,
  input  cst2_pkg::pair_t                       pair,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [cst2_pkg::OUT_DATA_BITS-1:0]    out_tdata,
  output logic                                  out_tlast
);

  logic             held_r;
  logic             rank_r;
  cst2_pkg::pair_t  pair_r;
  logic             beat;
  logic             done;

  assign beat     = out_tvalid && out_tready;
  assign done     = beat && (rank_r == cst2_pkg::RANK_SECOND);
  assign pair_rdy = !held_r || done;

  assign out_tvalid = held_r;
  assign out_tlast  = (rank_r == cst2_pkg::RANK_SECOND);
  assign out_tdata  = {
    {(cst2_pkg::OUT_DATA_BITS - cst2_pkg::NUMBER_BITS - 1){1'b0}},
    rank_r,
    (rank_r == cst2_pkg::RANK_SECOND) ? pair_r.second_number : pair_r.best_number
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      rank_r <= cst2_pkg::RANK_BEST;
    end else if (pair_vld && pair_rdy) begin
      held_r <= 1'b1;
      rank_r <= cst2_pkg::RANK_BEST;
    end else if (done) begin
      held_r <= 1'b0;
      rank_r <= cst2_pkg::RANK_BEST;
    end else if (beat) begin
      rank_r <= cst2_pkg::RANK_SECOND;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_vld && pair_rdy) begin
      pair_r <= pair;
    end
  end

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    beat && rank_r == cst2_pkg::RANK_BEST |=> held_r && rank_r == cst2_pkg::RANK_SECOND)
    else $error("second of pair not presented after first");

  a_load_starts_best: assert property (@(posedge clk) disable iff (!rst_n)
    pair_vld && pair_rdy |=> held_r && rank_r == cst2_pkg::RANK_BEST)
    else $error("loaded pair does not start at best rank");

  a_idle_rank: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> rank_r == cst2_pkg::RANK_BEST)
    else $error("rank left over in empty buffer");

endmodule
